/* hdl/grid_contour_ray_cast_top_assert.svh */
// assertion macros used by the block's top module
`ifndef GRID_CONTOUR_RAY_CAST_TOP_ASSERT_SVH
`define GRID_CONTOUR_RAY_CAST_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GCRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gcrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gcrc_pkg;

  localparam int COORD_WIDTH_DEF = 31;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int EPS_WIDTH = 16;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd66;

  // register map
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_REF_X   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REF_Y   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EPSILON = 2'd2;

endpackage

`default_nettype wire

/* hdl/grid_contour_ray_cast_top.sv */
`timescale 1ns / 1ps
`default_nettype none
//  channel   dir   handshake           payload
//  in_       in    in_valid/in_stall   in_vertex_x, in_vertex_y, in_first_vertex, in_last_vertex
//  out_      out   out_valid/out_stall out_inside_res
//  cfg       in    psel/penable/pready paddr, pwdata, prdata (ref_x, ref_y, epsilon)
//
//  one vertex per cycle unless in_stall holds it; a beat is registered in the input
//  register, where the crossing test runs against the previous and first vertex, then
//  its result (last vertex only) is registered in the output register
//  rst_n is synchronous: resets the crossing state, the valids and the config registers
//  in_stall rises only while a last vertex waits behind an undelivered result

module grid_contour_ray_cast_top
  import gcrc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int DATA_W     = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB   = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int ADDR_W     = ADDR_LSB + REG_IDX_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [COORD_WIDTH-1:0] in_vertex_x,
  input  wire logic [COORD_WIDTH-1:0] in_vertex_y,
  input  wire logic                   in_first_vertex,
  input  wire logic                   in_last_vertex,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_inside_res,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_W-1:0]      paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic      [DATA_W-1:0]      prdata,
  output logic                        pready
);

`include "grid_contour_ray_cast_top_assert.svh"

  logic [COORD_WIDTH-1:0] ref_x, ref_y;
  logic [EPS_WIDTH-1:0]   epsilon;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [COORD_WIDTH-1:0] s1_x_r, s1_y_r;
  logic                   s1_first_r, s1_last_r;
  logic [COORD_WIDTH-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r;
  logic                   parity_r, parity_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_inside_r;
  logic                   s1_go, s1_fire, in_fire, hit_par;

  gcrc_cfg #(
    .COORD_WIDTH (COORD_WIDTH),
    .DATA_W      (DATA_W),
    .ADDR_LSB    (ADDR_LSB),
    .ADDR_W      (ADDR_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ref_x   (ref_x),
    .ref_y   (ref_y),
    .epsilon (epsilon)
  );

  gcrc_hit #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_hit (
    .ref_x   (ref_x),
    .ref_y   (ref_y),
    .epsilon (epsilon),
    .cur_x   (s1_x_r),
    .cur_y   (s1_y_r),
    .prev_x  (prev_x_r),
    .prev_y  (prev_y_r),
    .start_x (start_x_r),
    .start_y (start_y_r),
    .first   (s1_first_r),
    .last    (s1_last_r),
    .hit_par (hit_par)
  );

  // a last vertex may leave only when the output register is empty or its result is taken in the same cycle
  assign s1_go    = !s1_last_r || !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  assign parity_nxt = (s1_first_r ? 1'b0 : parity_r) ^ hit_par;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      parity_r    <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        parity_r <= parity_nxt;
        prev_x_r <= s1_x_r;
        prev_y_r <= s1_y_r;
        if (s1_first_r) begin
          start_x_r <= s1_x_r;
          start_y_r <= s1_y_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r     <= in_vertex_x;
      s1_y_r     <= in_vertex_y;
      s1_first_r <= in_first_vertex;
      s1_last_r  <= in_last_vertex;
    end
    if (s1_fire && s1_last_r) begin
      out_inside_r <= parity_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

  `GCRC_ASSERT_NOW(a_stall_only_on_last, clk, rst_n, in_stall,
    s1_valid_r && s1_last_r && out_valid_r && out_stall, "in_stall without a blocked last vertex")
  `GCRC_ASSERT_NEXT(a_last_makes_result, clk, rst_n, s1_fire && s1_last_r,
    out_valid_r && (out_inside_r == $past(parity_nxt)), "closing vertex lost its result")
  `GCRC_ASSERT_NEXT(a_first_restarts, clk, rst_n, s1_fire && s1_first_r,
    (parity_r == $past(hit_par)) && (start_x_r == $past(s1_x_r)), "first vertex did not restart")
  `GCRC_ASSERT_NEXT(a_prev_follows, clk, rst_n, s1_fire,
    (prev_x_r == $past(s1_x_r)) && (prev_y_r == $past(s1_y_r)), "previous vertex not kept")

endmodule

`default_nettype wire

/* hdl/gcrc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcrc_cfg
  import gcrc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DATA_W      = 32,
  parameter int ADDR_LSB    = 2,
  parameter int ADDR_W      = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_W-1:0]      paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic      [DATA_W-1:0]      prdata,
  output logic                        pready,
  output logic      [COORD_WIDTH-1:0] ref_x,
  output logic      [COORD_WIDTH-1:0] ref_y,
  output logic      [EPS_WIDTH-1:0]   epsilon
);

  logic [COORD_WIDTH-1:0] ref_x_r, ref_x_nxt;
  logic [COORD_WIDTH-1:0] ref_y_r, ref_y_nxt;
  logic [EPS_WIDTH-1:0]   eps_r, eps_nxt;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   wr_en;

  assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    ref_x_nxt = ref_x_r;
    ref_y_nxt = ref_y_r;
    eps_nxt   = eps_r;
    if (wr_en) begin
      case (reg_idx)
        REG_REF_X:   ref_x_nxt = pwdata[COORD_WIDTH-1:0];
        REG_REF_Y:   ref_y_nxt = pwdata[COORD_WIDTH-1:0];
        REG_EPSILON: eps_nxt   = pwdata[EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REF_X:   prdata = DATA_W'(ref_x_r);
      REG_REF_Y:   prdata = DATA_W'(ref_y_r);
      REG_EPSILON: prdata = DATA_W'(eps_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      eps_r   <= EPS_RESET;
    end else begin
      ref_x_r <= ref_x_nxt;
      ref_y_r <= ref_y_nxt;
      eps_r   <= eps_nxt;
    end
  end

  assign ref_x   = ref_x_r;
  assign ref_y   = ref_y_r;
  assign epsilon = eps_r;

endmodule

`default_nettype wire

/* hdl/gcrc_hit.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcrc_hit
  import gcrc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic [COORD_WIDTH-1:0] ref_x,
  input  wire logic [COORD_WIDTH-1:0] ref_y,
  input  wire logic [EPS_WIDTH-1:0]   epsilon,
  input  wire logic [COORD_WIDTH-1:0] cur_x,
  input  wire logic [COORD_WIDTH-1:0] cur_y,
  input  wire logic [COORD_WIDTH-1:0] prev_x,
  input  wire logic [COORD_WIDTH-1:0] prev_y,
  input  wire logic [COORD_WIDTH-1:0] start_x,
  input  wire logic [COORD_WIDTH-1:0] start_y,
  input  wire logic                   first,
  input  wire logic                   last,
  output logic                        hit_par
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = FRAC_BITS + 1;
  localparam int CMP_W = (CW > EPS_WIDTH) ? CW : EPS_WIDTH;
  localparam logic [CW-1:0] FRAC_MASK = CW'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [DW-1:0] FRAC_ONE  = DW'(64'd1 << FRAC_BITS);

  function automatic logic [DW-1:0] grid_dist(input logic [CW-1:0] v);
    logic [DW-1:0] f;
    logic [DW-1:0] g;
    f = DW'(v & FRAC_MASK);
    g = FRAC_ONE - f;
    return (f < g) ? f : g;
  endfunction

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic within_eps(input logic [CW-1:0] d,
                                      input logic [EPS_WIDTH-1:0] e);
    return CMP_W'(d) < CMP_W'(e);
  endfunction

  logic          ray_y;
  logic [CW-1:0] r_acr, r_alg;
  logic [CW-1:0] c_acr, c_alg, p_acr, p_alg, s_acr, s_alg;
  logic          vtx_hit, prev_hit, close_hit;

  assign ray_y = grid_dist(ref_x) < grid_dist(ref_y);

  // swap to (across, along) for the chosen ray direction
  assign r_acr = ray_y ? ref_x   : ref_y;
  assign r_alg = ray_y ? ref_y   : ref_x;
  assign c_acr = ray_y ? cur_x   : cur_y;
  assign c_alg = ray_y ? cur_y   : cur_x;
  assign p_acr = ray_y ? prev_x  : prev_y;
  assign p_alg = ray_y ? prev_y  : prev_x;
  assign s_acr = ray_y ? start_x : start_y;
  assign s_alg = ray_y ? start_y : start_x;

  assign vtx_hit = within_eps(abs_diff(c_acr, r_acr), epsilon) && (c_alg > r_alg);

  // edge from prev to current
  assign prev_hit = !first
                 && within_eps(abs_diff(p_alg, c_alg), epsilon)
                 && (c_alg > r_alg)
                 && (((p_acr < r_acr) && (c_acr > r_acr)) ||
                     ((p_acr > r_acr) && (c_acr < r_acr)));

  // closing edge from current back to start
  assign close_hit = last && !first
                  && within_eps(abs_diff(c_alg, s_alg), epsilon)
                  && (s_alg > r_alg)
                  && (((c_acr < r_acr) && (s_acr > r_acr)) ||
                      ((c_acr > r_acr) && (s_acr < r_acr)));

  assign hit_par = vtx_hit ^ prev_hit ^ close_hit;

endmodule

`default_nettype wire
